// ===== hdl/mppp_pkg.sv =====
// shared types and constants of the publish packet parser
`default_nettype none

package mppp_pkg;

   // longest remaining-length field, in bytes (1 to 4)
   localparam int unsigned MAX_LENGTH_BYTES = 4;

   localparam logic [6:0] LEN_GROUP_MASK = 7'h7f;
   localparam logic [7:0] LEN_CONT_BIT   = 8'h80;
   localparam logic [7:0] CHAR_S         = 8'h73;
   localparam logic [7:0] CHAR_P         = 8'h70;
   localparam logic [15:0] TOPIC_S_INDEX = 16'd3;
   localparam logic [15:0] TOPIC_P_INDEX = 16'd4;

   localparam logic [2:0] CLS_HEADER  = 3'd0;
   localparam logic [2:0] CLS_LENGTH  = 3'd1;
   localparam logic [2:0] CLS_TLEN    = 3'd2;
   localparam logic [2:0] CLS_TOPIC   = 3'd3;
   localparam logic [2:0] CLS_PAYLOAD = 3'd4;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_TLEN_HI,
      PH_TLEN_LO,
      PH_TOPIC,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  byte_class;
      logic [3:0]  packet_type;
      logic [27:0] remaining_length;
      logic [15:0] topic_length;
      logic [27:0] payload_length;
      logic        end_of_packet;
      logic        parse_error;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/mppp_parser.sv =====
// per-byte parse state and result logic
`default_nettype none

module mppp_parser (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_wr_en,
   input  wire logic            csr_wr_data,
   input  wire logic            in_fire,
   input  wire mppp_pkg::req_type in_beat,
   output mppp_pkg::rsp_type    res
);

   mppp_pkg::phase_type phase_ff, phase_in;
   logic        rewrite_ff;
   logic [3:0]  type_ff, type_in;
   logic [27:0] accum_ff, accum_in;
   logic [1:0]  count_ff, count_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [27:0] left_ff, left_in;
   logic [15:0] tidx_ff, tidx_in;
   logic [27:0] plen_ff, plen_in;

   logic [7:0]  b;
   logic        hdr;
   logic [27:0] grp;
   logic [2:0]  n_len;
   logic [27:0] left_dec;
   logic        last;
   logic [15:0] tl_full;
   logic [16:0] tl_plus2;
   logic [28:0] diff;
   logic [15:0] tidx_inc;

   always_comb begin
      b        = in_beat.rx_byte;
      n_len    = {1'b0, count_ff} + 3'd1;
      left_dec = left_ff - 28'd1;
      last     = (left_dec == 28'd0);
      tl_full  = {tlen_ff[15:8], b};
      tl_plus2 = {1'b0, tl_full} + 17'd2;
      diff     = {1'b0, accum_ff} - {12'd0, tl_plus2};
      tidx_inc = tidx_ff + 16'd1;
      unique case (count_ff)
         2'd0: grp = {21'd0, b[6:0] & mppp_pkg::LEN_GROUP_MASK};
         2'd1: grp = {14'd0, b[6:0] & mppp_pkg::LEN_GROUP_MASK, 7'd0};
         2'd2: grp = {7'd0, b[6:0] & mppp_pkg::LEN_GROUP_MASK, 14'd0};
         2'd3: grp = {b[6:0] & mppp_pkg::LEN_GROUP_MASK, 21'd0};
      endcase

      phase_in = phase_ff;
      type_in  = type_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      tlen_in  = tlen_ff;
      left_in  = left_ff;
      tidx_in  = tidx_ff;
      plen_in  = plen_ff;
      hdr      = 1'b0;

      res.out_byte       = b;
      res.byte_class     = mppp_pkg::CLS_HEADER;
      res.topic_length   = 16'd0;
      res.payload_length = 28'd0;
      res.end_of_packet  = 1'b0;
      res.parse_error    = 1'b0;

      if (in_beat.frame_start) begin
         hdr = 1'b1;
      end else begin
         unique case (phase_ff)
            mppp_pkg::PH_LENGTH: begin
               res.byte_class = mppp_pkg::CLS_LENGTH;
               // groups never overlap, so or-ing equals adding
               accum_in = accum_ff | grp;
               count_in = n_len[1:0];
               if ((b & mppp_pkg::LEN_CONT_BIT) != 8'd0) begin
                  if (n_len >= 3'(mppp_pkg::MAX_LENGTH_BYTES)) begin
                     res.parse_error = 1'b1;
                     phase_in        = mppp_pkg::PH_HEADER;
                  end
               end else begin
                  left_in = accum_ff | grp;
                  if ((accum_ff | grp) == 28'd0) begin
                     res.end_of_packet = 1'b1;
                     phase_in          = mppp_pkg::PH_HEADER;
                  end else begin
                     phase_in = mppp_pkg::PH_TLEN_HI;
                  end
               end
            end
            mppp_pkg::PH_TLEN_HI: begin
               res.byte_class = mppp_pkg::CLS_TLEN;
               left_in        = left_dec;
               tlen_in        = {b, 8'd0};
               if (last) begin
                  res.parse_error   = 1'b1;
                  res.end_of_packet = 1'b1;
                  phase_in          = mppp_pkg::PH_HEADER;
               end else begin
                  phase_in = mppp_pkg::PH_TLEN_LO;
               end
            end
            mppp_pkg::PH_TLEN_LO: begin
               res.byte_class   = mppp_pkg::CLS_TLEN;
               res.topic_length = tl_full;
               left_in          = left_dec;
               tlen_in          = tl_full;
               if (diff[28]) begin
                  // topic does not fit in the remaining length
                  res.parse_error   = 1'b1;
                  res.end_of_packet = last;
                  phase_in          = mppp_pkg::PH_HEADER;
               end else begin
                  res.payload_length = diff[27:0];
                  plen_in            = diff[27:0];
                  tidx_in            = 16'd0;
                  if (last) begin
                     res.end_of_packet = 1'b1;
                     phase_in          = mppp_pkg::PH_HEADER;
                  end else if (tl_full == 16'd0) begin
                     phase_in = mppp_pkg::PH_PAYLOAD;
                  end else begin
                     phase_in = mppp_pkg::PH_TOPIC;
                  end
               end
            end
            mppp_pkg::PH_TOPIC: begin
               res.byte_class     = mppp_pkg::CLS_TOPIC;
               res.topic_length   = tlen_ff;
               res.payload_length = plen_ff;
               left_in            = left_dec;
               tidx_in            = tidx_inc;
               if (rewrite_ff) begin
                  if (tidx_ff == mppp_pkg::TOPIC_S_INDEX) begin
                     res.out_byte = mppp_pkg::CHAR_S;
                  end else if (tidx_ff == mppp_pkg::TOPIC_P_INDEX) begin
                     res.out_byte = mppp_pkg::CHAR_P;
                  end
               end
               if (last) begin
                  res.end_of_packet = 1'b1;
                  phase_in          = mppp_pkg::PH_HEADER;
               end else if (tidx_inc == tlen_ff) begin
                  phase_in = mppp_pkg::PH_PAYLOAD;
               end
            end
            mppp_pkg::PH_PAYLOAD: begin
               res.byte_class     = mppp_pkg::CLS_PAYLOAD;
               res.topic_length   = tlen_ff;
               res.payload_length = plen_ff;
               left_in            = left_dec;
               if (last) begin
                  res.end_of_packet = 1'b1;
                  phase_in          = mppp_pkg::PH_HEADER;
               end
            end
            default: hdr = 1'b1;
         endcase
      end

      // fixed header byte: start a fresh packet
      if (hdr) begin
         type_in  = b[7:4];
         accum_in = 28'd0;
         count_in = 2'd0;
         tlen_in  = 16'd0;
         left_in  = 28'd0;
         tidx_in  = 16'd0;
         phase_in = mppp_pkg::PH_LENGTH;
         res.byte_class     = mppp_pkg::CLS_HEADER;
         res.topic_length   = 16'd0;
         res.payload_length = 28'd0;
         res.end_of_packet  = 1'b0;
         res.parse_error    = 1'b0;
         res.out_byte       = b;
      end

      res.packet_type      = type_in;
      res.remaining_length = accum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mppp_pkg::PH_HEADER;
         rewrite_ff <= 1'b0;
         type_ff    <= 4'd0;
         accum_ff   <= 28'd0;
         count_ff   <= 2'd0;
         tlen_ff    <= 16'd0;
         left_ff    <= 28'd0;
         tidx_ff    <= 16'd0;
         plen_ff    <= 28'd0;
      end else begin
         if (csr_wr_en) begin
            rewrite_ff <= csr_wr_data;
         end
         if (in_fire) begin
            phase_ff <= phase_in;
            type_ff  <= type_in;
            accum_ff <= accum_in;
            count_ff <= count_in;
            tlen_ff  <= tlen_in;
            left_ff  <= left_in;
            tidx_ff  <= tidx_in;
            plen_ff  <= plen_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mppp_obuf.sv =====
// result register with skid stage
`default_nettype none

module mppp_obuf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire mppp_pkg::rsp_type push_data,
   output logic                  full,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mppp_pkg::rsp_type     rsp_payload
);

   logic              out_valid_ff;
   logic              skid_valid_ff;
   mppp_pkg::rsp_type out_data_ff;
   mppp_pkg::rsp_type skid_data_ff;
   logic              take;

   assign take        = out_valid_ff & ~rsp_stall;
   assign full        = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !take) begin
            skid_data_ff <= push_data;
         end else begin
            out_data_ff <= push_data;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mqtt_publish_packet_parser.sv =====
// top level of the publish packet parser
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  req     | req_valid, req_stall, req_payload      | in
//  rsp     | rsp_valid, rsp_stall, rsp_payload      | out
//  csr     | csr_wr_en, csr_wr_data (rewrite mode)  | in
//
// one byte per cycle while req_stall is low: each accepted beat updates the
// parse state in the same edge, and its result beat is registered for rsp
// the result register plus a one-beat skid stage decouple the two sides, so
// req_stall only rises after the consumer has stalled with two beats held
// synchronous active-high reset returns the parser to the fixed-header phase
// and clears the rewrite mode; no result beat is shown after reset
`default_nettype none

module mqtt_publish_packet_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   // byte input
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mppp_pkg::req_type req_payload,
   // result output
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mppp_pkg::rsp_type      rsp_payload,
   // rewrite mode register
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data
);

   logic              req_fire;
   logic              buf_full;
   mppp_pkg::rsp_type step_res;

   // a beat is taken whenever the skid stage has room
   assign req_stall = buf_full;
   assign req_fire  = req_valid & ~buf_full;

   // parse state and per-byte decode
   mppp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_fire     (req_fire),
      .in_beat     (req_payload),
      .res         (step_res)
   );

   // result register and skid stage
   mppp_obuf u_obuf (
      .clock       (clock),
      .reset       (reset),
      .push        (req_fire),
      .push_data   (step_res),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== hdl/mppp_checker.sv =====
// port-level checks of the publish packet parser and their binding
`default_nettype none

module mppp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire mppp_pkg::rsp_type rsp_payload
);

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   // a header byte starts a packet with nothing decoded yet
   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.byte_class == mppp_pkg::CLS_HEADER |->
         !rsp_payload.end_of_packet && !rsp_payload.parse_error &&
         rsp_payload.remaining_length == 28'd0)
      else $error("header byte with decoded fields");

   // errors come only from length or topic length bytes
   a_err_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.parse_error |->
         rsp_payload.byte_class == mppp_pkg::CLS_LENGTH ||
         rsp_payload.byte_class == mppp_pkg::CLS_TLEN)
      else $error("error flagged on wrong byte class");

   // input only stalls while the output side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && $past(rsp_valid && rsp_stall))
      else $error("input stalled with output free");

endmodule

bind mqtt_publish_packet_parser mppp_checker u_mppp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the mqtt publish packet parser, with its own parse predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // generous ceiling on the whole run, far above the slowest legal run
   localparam int unsigned CYCLE_LIMIT = 400000;

   // ------------------------------------------------------------------
   // parse predictor and store of expected result beats
   // ------------------------------------------------------------------
   class publish_parse_scoreboard;
      mppp_pkg::phase_type phase;
      logic [3:0]          type_reg;
      logic [27:0]         length_accum;
      logic [1:0]          length_count;
      logic [15:0]         tname_len;
      logic [27:0]         bytes_left;
      logic [15:0]         topic_index;
      logic                rewrite_mode;
      mppp_pkg::rsp_type   predicted_results[$];
      int unsigned         errors;

      function new();
         phase        = mppp_pkg::PH_HEADER;
         type_reg     = '0;
         length_accum = '0;
         length_count = '0;
         tname_len    = '0;
         bytes_left   = '0;
         topic_index  = '0;
         rewrite_mode = 1'b0;
         errors       = 0;
      endfunction

      // advance the parse state by one byte and return the result beat it gives
      function mppp_pkg::rsp_type parse_byte(mppp_pkg::req_type r);
         mppp_pkg::rsp_type e;
         logic [2:0]        n;
         logic              last;
         e = '0;
         e.out_byte = r.rx_byte;
         e.byte_class = mppp_pkg::CLS_HEADER;
         if (r.frame_start || phase == mppp_pkg::PH_HEADER) begin
            // new fixed header, any packet in progress is dropped
            type_reg     = r.rx_byte[7:4];
            length_accum = '0;
            length_count = '0;
            tname_len    = '0;
            bytes_left   = '0;
            topic_index  = '0;
            phase        = mppp_pkg::PH_LENGTH;
         end else if (phase == mppp_pkg::PH_LENGTH) begin
            n = {1'b0, length_count} + 3'd1;
            e.byte_class = mppp_pkg::CLS_LENGTH;
            length_accum = length_accum + (28'(r.rx_byte[6:0]) << (7 * length_count));
            length_count = n[1:0];
            if (r.rx_byte[7]) begin
               if (n >= mppp_pkg::MAX_LENGTH_BYTES) begin
                  e.parse_error = 1'b1;
                  phase = mppp_pkg::PH_HEADER;
               end
            end else begin
               bytes_left = length_accum;
               if (bytes_left == 0) begin
                  e.end_of_packet = 1'b1;
                  phase = mppp_pkg::PH_HEADER;
               end else begin
                  phase = mppp_pkg::PH_TLEN_HI;
               end
            end
         end else begin
            bytes_left = bytes_left - 28'd1;
            last = (bytes_left == 0);
            case (phase)
               mppp_pkg::PH_TLEN_HI: begin
                  e.byte_class = mppp_pkg::CLS_TLEN;
                  tname_len = {r.rx_byte, 8'h00};
                  if (last) begin
                     e.parse_error = 1'b1;
                     e.end_of_packet = 1'b1;
                     phase = mppp_pkg::PH_HEADER;
                  end else begin
                     phase = mppp_pkg::PH_TLEN_LO;
                  end
               end
               mppp_pkg::PH_TLEN_LO: begin
                  e.byte_class = mppp_pkg::CLS_TLEN;
                  tname_len = {tname_len[15:8], r.rx_byte};
                  e.topic_length = tname_len;
                  if (32'(tname_len) + 32'd2 > 32'(length_accum)) begin
                     e.parse_error = 1'b1;
                     e.end_of_packet = last;
                     phase = mppp_pkg::PH_HEADER;
                  end else begin
                     e.payload_length = length_accum - 28'd2 - 28'(tname_len);
                     topic_index = '0;
                     if (last) begin
                        e.end_of_packet = 1'b1;
                        phase = mppp_pkg::PH_HEADER;
                     end else begin
                        phase = (tname_len == 0) ? mppp_pkg::PH_PAYLOAD
                                                 : mppp_pkg::PH_TOPIC;
                     end
                  end
               end
               mppp_pkg::PH_TOPIC: begin
                  e.byte_class = mppp_pkg::CLS_TOPIC;
                  e.topic_length = tname_len;
                  e.payload_length = length_accum - 28'd2 - 28'(tname_len);
                  if (rewrite_mode) begin
                     if (topic_index == mppp_pkg::TOPIC_S_INDEX)
                        e.out_byte = mppp_pkg::CHAR_S;
                     else if (topic_index == mppp_pkg::TOPIC_P_INDEX)
                        e.out_byte = mppp_pkg::CHAR_P;
                  end
                  topic_index = topic_index + 16'd1;
                  if (last) begin
                     e.end_of_packet = 1'b1;
                     phase = mppp_pkg::PH_HEADER;
                  end else if (topic_index == tname_len) begin
                     phase = mppp_pkg::PH_PAYLOAD;
                  end
               end
               default: begin
                  e.byte_class = mppp_pkg::CLS_PAYLOAD;
                  e.topic_length = tname_len;
                  e.payload_length = length_accum - 28'd2 - 28'(tname_len);
                  if (last) begin
                     e.end_of_packet = 1'b1;
                     phase = mppp_pkg::PH_HEADER;
                  end
               end
            endcase
         end
         e.packet_type = type_reg;
         e.remaining_length = length_accum;
         return e;
      endfunction

      function void note_rx_beat(mppp_pkg::req_type r);
         predicted_results.push_back(parse_byte(r));
      endfunction

      function void compare_field(string field, logic [27:0] want, logic [27:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $realtime, field, want, got);
         end
      endfunction

      function void check_result_beat(mppp_pkg::rsp_type a);
         mppp_pkg::rsp_type e;
         if (predicted_results.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result beat 0x%0h, expected none", $realtime, a);
            return;
         end
         e = predicted_results.pop_front();
         compare_field("out_byte", 28'(e.out_byte), 28'(a.out_byte));
         compare_field("byte_class", 28'(e.byte_class), 28'(a.byte_class));
         compare_field("packet_type", 28'(e.packet_type), 28'(a.packet_type));
         compare_field("remaining_length", e.remaining_length, a.remaining_length);
         compare_field("topic_length", 28'(e.topic_length), 28'(a.topic_length));
         compare_field("payload_length", e.payload_length, a.payload_length);
         compare_field("end_of_packet", 28'(e.end_of_packet), 28'(a.end_of_packet));
         compare_field("parse_error", 28'(e.parse_error), 28'(a.parse_error));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // clock, reset and the block itself
   // ------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   mppp_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   mppp_pkg::rsp_type rsp_payload;
   logic              csr_wr_en;
   logic              csr_wr_data;

   publish_parse_scoreboard sb;

   int unsigned cycle_count = 0;
   int unsigned beats_sent = 0;
   // chance of an idle burst, in percent: per beat on the byte side, per cycle on the result side
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;

   always #1 clock = ~clock;

   mqtt_publish_packet_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result_beat(rsp_payload);
   end

   // result side back-pressure: stall bursts of random length
   initial begin : rsp_stall_gen
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) stall_left--;
         else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct)
            stall_left = $urandom_range(1, 15);
         rsp_stall = (stall_left != 0);
      end
   end

   // ------------------------------------------------------------------
   // drive tasks
   // ------------------------------------------------------------------

   // present one byte beat and hold it until it is taken
   task automatic send_byte(input logic [7:0] b, input logic fs);
      mppp_pkg::req_type p;
      p.rx_byte = b;
      p.frame_start = fs;
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_payload = p;
      do @(posedge clock); while (req_stall);
      sb.note_rx_beat(p);
      beats_sent++;
   endtask

   // stop sending and wait until every predicted beat has come back
   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.predicted_results.size() != 0) @(posedge clock);
      // result register plus skid stage
      repeat (3) @(posedge clock);
   endtask

   // only called with the parser idle
   task automatic write_rewrite_mode(input logic mode);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = mode;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.rewrite_mode = mode;
   endtask

   // one random packet: mostly well formed, some cut short, some with a topic that
   // does not fit, some bare length fields and some plain noise
   task automatic send_random_packet();
      logic [7:0]  pkt[$];
      logic [7:0]  d;
      int unsigned kind;
      int unsigned tl;
      int unsigned pl;
      int unsigned rl;
      int unsigned v;
      int unsigned cut;
      kind = $urandom_range(0, 99);
      if (kind >= 93) begin
         repeat ($urandom_range(1, 6))
            send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
         return;
      end
      // fixed header, mostly publish
      pkt.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : {4'h3, 4'($urandom)});
      if (kind >= 87) begin
         // bare length field of random groups, may run long
         repeat ($urandom_range(1, mppp_pkg::MAX_LENGTH_BYTES)) pkt.push_back(8'($urandom));
      end else begin
         if (kind >= 80) begin
            // topic length that cannot fit, or a packet ending inside the topic length
            rl = $urandom_range(1, 12);
            tl = $urandom_range(rl - 1, rl + 20);
            pl = 0;
         end else begin
            tl = $urandom_range(0, 10);
            pl = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
            rl = tl + pl + 2;
         end
         v = rl;
         do begin
            d = 8'(v % 128);
            v = v / 128;
            if (v != 0) d[7] = 1'b1;
            pkt.push_back(d);
         end while (v != 0);
         // occasional non-minimal length with a trailing zero group
         if (pkt.size() - 1 < mppp_pkg::MAX_LENGTH_BYTES && $urandom_range(0, 9) == 0) begin
            pkt[pkt.size() - 1][7] = 1'b1;
            pkt.push_back(8'h00);
         end
         pkt.push_back(tl[15:8]);
         pkt.push_back(tl[7:0]);
         if (kind < 80) repeat (tl + pl) pkt.push_back(8'($urandom));
      end
      cut = pkt.size();
      if (kind >= 70 && kind < 80 && cut > 1) cut = $urandom_range(1, cut - 1);
      for (int unsigned i = 0; i < cut; i++) begin
         if (i == 0)
            send_byte(pkt[i], (sb.phase == mppp_pkg::PH_HEADER) ?
                              1'($urandom_range(0, 1)) : 1'b1);
         else
            send_byte(pkt[i], 1'b0);
      end
   endtask

   task automatic run_random(input int unsigned n_beats);
      int unsigned target;
      target = beats_sent + n_beats;
      while (beats_sent < target) begin
         // now and then hold off until the parser has caught up
         if ($urandom_range(0, 39) == 0) wait_drain();
         send_random_packet();
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_rewrite_mode(1'b0);

      // directed corner packets
      req_idle_pct = 20;
      rsp_idle_pct = 10;
      // zero remaining length ends on the length byte
      send_byte(8'h30, 1'b1);
      send_byte(8'h00, 1'b0);
      // overlong length field, largest accumulated value
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      // packet ends on the high topic-length byte
      send_byte(8'h32, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      // largest topic length, does not fit, on the last byte
      send_byte(8'h30, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      // topic does not fit, packet still running
      send_byte(8'h30, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h04, 1'b0);
      // empty topic, rest is payload
      send_byte(8'h00, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'haa, 1'b0);
      // largest legal length, then cut off by a frame start
      send_byte(8'h3d, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h3f, 1'b1);
      wait_drain();

      // rewrite on, heavy idling on both sides
      write_rewrite_mode(1'b1);
      req_idle_pct = 30;
      rsp_idle_pct = 12;
      run_random(250);
      wait_drain();

      // rewrite off, mostly result-side pressure
      write_rewrite_mode(1'b0);
      req_idle_pct = 5;
      rsp_idle_pct = 25;
      run_random(250);
      wait_drain();

      // rewrite on, full rate to the end
      write_rewrite_mode(1'b1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(200);
      wait_drain();

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.predicted_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
